@@ rtl/core/sprs_pkg.sv @@
`default_nettype none
package sprs_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int SLOT_BYTES   = 4;
    localparam int HEADER_BYTES = 6;
    localparam int MAX_SLOTS    = 1024;

    localparam int PAGE_AW = $clog2(PAGE_BYTES);
    localparam int PTR_W   = PAGE_AW + 1;
    localparam int SLOT_AW = $clog2(MAX_SLOTS);
    localparam int CNT_W   = SLOT_AW + 1;

    // Field widths of the command and result ports.
    localparam int ACT_W  = 3;
    localparam int LEN_W  = 12;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 10;
    localparam int OFF_W  = 12;
    localparam int STAT_W = 3;

    // Command queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [ACT_W-1:0] ACT_INIT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BYTE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_BADSLOT = 3'd2,
        ST_DELETED = 3'd3,
        ST_NOOPEN  = 3'd4,
        ST_OPEN    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_INSERT,
        OP_BYTE,
        OP_GET,
        OP_DELETE,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [OFF_W-1:0]  boff;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_TABLE,
        B_PAGE
    } t_bstate;

endpackage
`default_nettype wire

@@ rtl/core/slotted_page_record_store.sv @@
// Results: o_done is registered. Init, insert, record byte, delete and undefined actions finish
// from idle, a get after the directory read, a read byte after the directory and then the page read.
// The back end retires one simple transaction per cycle while commands are queued; a get holds it
// through the registered directory read and a read through the directory and page reads.
// busy rises only when the two-entry command queue is full; results cannot be stalled.
// Reset is synchronous and clears the pointers, counts and queue, not page or directory.
`default_nettype none
module slotted_page_record_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [sprs_pkg::ACT_W-1:0]   i_action,
    input  wire logic [sprs_pkg::LEN_W-1:0]   i_record_length,
    input  wire logic [sprs_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic [sprs_pkg::IDX_W-1:0]   i_slot_index,
    input  wire logic [sprs_pkg::OFF_W-1:0]   i_byte_offset,
    output logic                              o_done,
    output logic [sprs_pkg::STAT_W-1:0]       o_status,
    output logic [sprs_pkg::IDX_W-1:0]        o_slot_index_out,
    output logic [sprs_pkg::OFF_W-1:0]        o_record_offset,
    output logic [sprs_pkg::LEN_W-1:0]        o_record_length_out,
    output logic [sprs_pkg::BYTE_W-1:0]       o_data_byte_out,
    output logic [sprs_pkg::LEN_W-1:0]        o_free_bytes_left
);
    import sprs_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    sprs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_action        (i_action),
        .i_record_length (i_record_length),
        .i_data_byte     (i_data_byte),
        .i_slot_index    (i_slot_index),
        .i_byte_offset   (i_byte_offset),
        .i_pop           (cmd_pop),
        .o_busy          (busy),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd)
    );

    sprs_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd_valid         (cmd_valid),
        .i_cmd               (cmd),
        .o_pop               (cmd_pop),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_slot_index_out    (o_slot_index_out),
        .o_record_offset     (o_record_offset),
        .o_record_length_out (o_record_length_out),
        .o_data_byte_out     (o_data_byte_out),
        .o_free_bytes_left   (o_free_bytes_left)
    );

endmodule
`default_nettype wire

@@ rtl/core/sprs_front.sv @@
`default_nettype none
module sprs_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [sprs_pkg::ACT_W-1:0]  i_action,
    input  wire logic [sprs_pkg::LEN_W-1:0]  i_record_length,
    input  wire logic [sprs_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic [sprs_pkg::IDX_W-1:0]  i_slot_index,
    input  wire logic [sprs_pkg::OFF_W-1:0]  i_byte_offset,
    input  wire logic                       i_pop,
    output logic                            o_busy,
    output logic                            o_cmd_valid,
    output sprs_pkg::t_cmd                  o_cmd
);
    import sprs_pkg::*;

    t_cmd             r_q [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QAW:0]     r_count, n_count;
    logic             accept;
    t_cmd             cmd_in;

    assign accept = i_start && !o_busy;

    // Decode the action into an operation; undefined actions become no-ops.
    always_comb begin
        cmd_in.len  = i_record_length;
        cmd_in.data = i_data_byte;
        cmd_in.idx  = i_slot_index;
        cmd_in.boff = i_byte_offset;
        unique case (i_action)
            ACT_INIT:   cmd_in.op = OP_INIT;
            ACT_INSERT: cmd_in.op = OP_INSERT;
            ACT_BYTE:   cmd_in.op = OP_BYTE;
            ACT_GET:    cmd_in.op = OP_GET;
            ACT_DELETE: cmd_in.op = OP_DELETE;
            ACT_READ:   cmd_in.op = OP_READ;
            default:    cmd_in.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (accept) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (accept && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!accept && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_busy      = (r_count == (QAW+1)'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("command queue count exceeds its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("command popped from an empty queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow an accepted transaction");

endmodule
`default_nettype wire

@@ rtl/core/sprs_back.sv @@
`default_nettype none
module sprs_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire sprs_pkg::t_cmd               i_cmd,
    output logic                              o_pop,
    output logic                              o_done,
    output logic [sprs_pkg::STAT_W-1:0]       o_status,
    output logic [sprs_pkg::IDX_W-1:0]        o_slot_index_out,
    output logic [sprs_pkg::OFF_W-1:0]        o_record_offset,
    output logic [sprs_pkg::LEN_W-1:0]        o_record_length_out,
    output logic [sprs_pkg::BYTE_W-1:0]       o_data_byte_out,
    output logic [sprs_pkg::LEN_W-1:0]        o_free_bytes_left
);
    import sprs_pkg::*;

    // Page and slot directory storage, not cleared by reset.
    logic [BYTE_W-1:0]  page_mem     [PAGE_BYTES];
    logic [PAGE_AW-1:0] slot_off_mem [MAX_SLOTS];
    logic [LEN_W-1:0]   slot_len_mem [MAX_SLOTS];

    t_bstate            r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [PTR_W-1:0]   r_alloc_ptr, n_alloc_ptr;
    logic [CNT_W-1:0]   r_slot_count, n_slot_count;
    logic [PTR_W-1:0]   r_free_cnt, n_free_cnt;
    logic [PAGE_AW-1:0] r_fill_ptr, n_fill_ptr;
    logic [LEN_W-1:0]   r_pending, n_pending;

    logic               r_done, n_done;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_slot_out, n_slot_out;
    logic [OFF_W-1:0]   r_roff, n_roff;
    logic [LEN_W-1:0]   r_rlen, n_rlen;
    logic [BYTE_W-1:0]  r_dout, n_dout;
    logic [LEN_W-1:0]   r_free_out, n_free_out;

    logic [PAGE_AW-1:0] r_tbl_off;
    logic [LEN_W-1:0]   r_tbl_len;
    logic [BYTE_W-1:0]  r_page_q;

    logic               off_we, len_we, page_we;
    logic [SLOT_AW-1:0] slot_wa, slot_ra;
    logic [PAGE_AW-1:0] off_wd;
    logic [LEN_W-1:0]   len_wd;
    logic [PAGE_AW-1:0] page_wa, page_ra;
    logic [BYTE_W-1:0]  page_wd;
    logic [PTR_W-1:0]   need_bytes;
    logic [PTR_W-1:0]   rd_addr;
    logic               idx_bad;

    // The directory is read at the queue head while idle and held afterwards.
    assign slot_ra    = (r_state == B_IDLE) ? i_cmd.idx[SLOT_AW-1:0] : r_cmd.idx[SLOT_AW-1:0];
    assign rd_addr    = {1'b0, r_tbl_off} + {1'b0, r_cmd.boff};
    assign page_ra    = rd_addr[PAGE_AW-1:0];
    assign need_bytes = {1'b0, i_cmd.len} + PTR_W'(SLOT_BYTES);
    assign idx_bad    = (CNT_W'(i_cmd.idx) >= r_slot_count);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_alloc_ptr  = r_alloc_ptr;
        n_slot_count = r_slot_count;
        n_free_cnt   = r_free_cnt;
        n_fill_ptr   = r_fill_ptr;
        n_pending    = r_pending;
        n_done       = 1'b0;
        n_status     = ST_OK;
        n_slot_out   = '0;
        n_roff       = '0;
        n_rlen       = '0;
        n_dout       = '0;
        n_free_out   = r_free_cnt[LEN_W-1:0];
        o_pop        = 1'b0;
        off_we       = 1'b0;
        len_we       = 1'b0;
        page_we      = 1'b0;
        slot_wa      = i_cmd.idx[SLOT_AW-1:0];
        off_wd       = r_alloc_ptr[PAGE_AW-1:0];
        len_wd       = '0;
        page_wa      = r_fill_ptr;
        page_wd      = i_cmd.data;

        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop  = 1'b1;
                    n_done = 1'b1;
                    unique case (i_cmd.op)
                        OP_INIT: begin
                            n_alloc_ptr  = PTR_W'(HEADER_BYTES);
                            n_slot_count = '0;
                            n_free_cnt   = PTR_W'(PAGE_BYTES - HEADER_BYTES);
                            n_fill_ptr   = '0;
                            n_pending    = '0;
                            n_free_out   = LEN_W'(PAGE_BYTES - HEADER_BYTES);
                        end
                        OP_INSERT: begin
                            if (r_pending != '0) begin
                                n_status = ST_OPEN;
                            end else if (r_slot_count >= CNT_W'(MAX_SLOTS) ||
                                         r_free_cnt < need_bytes) begin
                                n_status = ST_NOSPACE;
                            end else begin
                                off_we       = 1'b1;
                                len_we       = 1'b1;
                                slot_wa      = r_slot_count[SLOT_AW-1:0];
                                len_wd       = i_cmd.len;
                                n_slot_out   = IDX_W'(r_slot_count[SLOT_AW-1:0]);
                                n_roff       = OFF_W'(r_alloc_ptr[PAGE_AW-1:0]);
                                n_rlen       = i_cmd.len;
                                n_fill_ptr   = r_alloc_ptr[PAGE_AW-1:0];
                                n_pending    = i_cmd.len;
                                n_alloc_ptr  = r_alloc_ptr + {1'b0, i_cmd.len};
                                n_free_cnt   = r_free_cnt - need_bytes;
                                n_slot_count = r_slot_count + 1'b1;
                                n_free_out   = n_free_cnt[LEN_W-1:0];
                            end
                        end
                        OP_BYTE: begin
                            if (r_pending == '0) begin
                                n_status = ST_NOOPEN;
                            end else begin
                                page_we    = 1'b1;
                                n_fill_ptr = r_fill_ptr + 1'b1;
                                n_pending  = r_pending - 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (idx_bad) begin
                                n_status = ST_BADSLOT;
                            end else begin
                                len_we = 1'b1;
                            end
                        end
                        OP_GET, OP_READ: begin
                            if (i_cmd.op == OP_READ && r_pending != '0) begin
                                n_status = ST_OPEN;
                            end else if (idx_bad) begin
                                n_status = ST_BADSLOT;
                            end else begin
                                n_done  = 1'b0;
                                n_cmd   = i_cmd;
                                n_state = B_TABLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_TABLE: begin
                n_done  = 1'b1;
                n_state = B_IDLE;
                if (r_tbl_len == '0) begin
                    n_status = ST_DELETED;
                end else if (r_cmd.op == OP_GET) begin
                    n_roff = OFF_W'(r_tbl_off);
                    n_rlen = r_tbl_len;
                end else if (r_cmd.boff >= r_tbl_len ||
                             rd_addr >= PTR_W'(PAGE_BYTES)) begin
                    n_status = ST_BADSLOT;
                end else begin
                    n_done  = 1'b0;
                    n_state = B_PAGE;
                end
            end
            B_PAGE: begin
                n_done  = 1'b1;
                n_state = B_IDLE;
                n_roff  = OFF_W'(r_tbl_off);
                n_rlen  = r_tbl_len;
                n_dout  = r_page_q;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_alloc_ptr  <= PTR_W'(HEADER_BYTES);
            r_slot_count <= '0;
            r_free_cnt   <= PTR_W'(PAGE_BYTES - HEADER_BYTES);
            r_fill_ptr   <= '0;
            r_pending    <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_alloc_ptr  <= n_alloc_ptr;
            r_slot_count <= n_slot_count;
            r_free_cnt   <= n_free_cnt;
            r_fill_ptr   <= n_fill_ptr;
            r_pending    <= n_pending;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_status   <= n_status;
        r_slot_out <= n_slot_out;
        r_roff     <= n_roff;
        r_rlen     <= n_rlen;
        r_dout     <= n_dout;
        r_free_out <= n_free_out;
    end

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            slot_off_mem[slot_wa] <= off_wd;
        end
        r_tbl_off <= slot_off_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            slot_len_mem[slot_wa] <= len_wd;
        end
        r_tbl_len <= slot_len_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (page_we) begin
            page_mem[page_wa] <= page_wd;
        end
        r_page_q <= page_mem[page_ra];
    end

    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_slot_index_out    = r_slot_out;
    assign o_record_offset     = r_roff;
    assign o_record_length_out = r_rlen;
    assign o_data_byte_out     = r_dout;
    assign o_free_bytes_left   = r_free_out;

    // Every reserved byte is either free, in a record area or in the directory.
    a_space_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (17'(r_alloc_ptr) + 17'(r_free_cnt) + 17'(r_slot_count) * 17'(SLOT_BYTES))
            == 17'(PAGE_BYTES))
        else $error("page space accounting is inconsistent");

    // An open record always ends exactly at the free pointer.
    a_open_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != '0 |-> (PTR_W'(r_fill_ptr) + PTR_W'(r_pending)) == r_alloc_ptr)
        else $error("open record does not end at the free pointer");

    a_page_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_PAGE |=> r_done && r_status == ST_OK && r_state == B_IDLE)
        else $error("byte fetch did not complete with a result");

    a_table_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_TABLE |=> (r_done && r_state == B_IDLE) || (!r_done && r_state == B_PAGE))
        else $error("directory lookup neither finished nor fetched a byte");

endmodule
`default_nettype wire

@@ sim/tb_slotted_page_record_store.sv @@
module tb_slotted_page_record_store;
    timeunit 1ns;
    timeprecision 1ps;

    import sprs_pkg::*;

    // The two action codes that the block treats as no-ops.
    localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd7;

    typedef struct {
        t_status           status;
        logic [IDX_W-1:0]  slot;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  free_left;
    } t_page_resp;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [ACT_W-1:0]   i_action = '0;
    logic [LEN_W-1:0]   i_record_length = '0;
    logic [BYTE_W-1:0]  i_data_byte = '0;
    logic [IDX_W-1:0]   i_slot_index = '0;
    logic [OFF_W-1:0]   i_byte_offset = '0;
    logic               o_done;
    logic [STAT_W-1:0]  o_status;
    logic [IDX_W-1:0]   o_slot_index_out;
    logic [OFF_W-1:0]   o_record_offset;
    logic [LEN_W-1:0]   o_record_length_out;
    logic [BYTE_W-1:0]  o_data_byte_out;
    logic [LEN_W-1:0]   o_free_bytes_left;

    // Expected page state, kept in step with every accepted transaction.
    logic [BYTE_W-1:0]  page_bytes [PAGE_BYTES];
    logic [OFF_W-1:0]   slot_base [MAX_SLOTS];
    logic [LEN_W-1:0]   slot_size [MAX_SLOTS];
    logic [PTR_W-1:0]   alloc_ptr;
    logic [CNT_W-1:0]   used_slots;
    logic [PTR_W-1:0]   free_cnt;
    logic [PTR_W-1:0]   fill_ptr;
    logic [LEN_W-1:0]   fill_left;

    t_page_resp awaited_responses [$];
    int  fail_count = 0;
    int  commands_sent = 0;
    bit  gaps_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    slotted_page_record_store u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_action            (i_action),
        .i_record_length     (i_record_length),
        .i_data_byte         (i_data_byte),
        .i_slot_index        (i_slot_index),
        .i_byte_offset       (i_byte_offset),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_slot_index_out    (o_slot_index_out),
        .o_record_offset     (o_record_offset),
        .o_record_length_out (o_record_length_out),
        .o_data_byte_out     (o_data_byte_out),
        .o_free_bytes_left   (o_free_bytes_left)
    );

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic void clear_page_pointers();
        alloc_ptr  = PTR_W'(HEADER_BYTES);
        used_slots = '0;
        free_cnt   = PTR_W'(PAGE_BYTES - HEADER_BYTES);
        fill_ptr   = '0;
        fill_left  = '0;
    endfunction

    function automatic void predict_page_step(input logic [ACT_W-1:0] act,
                                              input logic [LEN_W-1:0] len,
                                              input logic [BYTE_W-1:0] data,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [OFF_W-1:0] boff);
        t_page_resp r;
        logic [OFF_W-1:0] base;
        logic [LEN_W-1:0] size;
        r.status = ST_OK;
        r.slot   = '0;
        r.offset = '0;
        r.length = '0;
        r.data   = '0;
        case (act)
            ACT_INIT: begin
                clear_page_pointers();
            end
            ACT_INSERT: begin
                if (fill_left != 0) begin
                    r.status = ST_OPEN;
                end else if (used_slots >= MAX_SLOTS || free_cnt < len + SLOT_BYTES) begin
                    r.status = ST_NOSPACE;
                end else begin
                    r.slot = used_slots[IDX_W-1:0];
                    slot_base[used_slots] = alloc_ptr[OFF_W-1:0];
                    slot_size[used_slots] = len;
                    r.offset   = alloc_ptr[OFF_W-1:0];
                    r.length   = len;
                    fill_ptr   = alloc_ptr;
                    fill_left  = len;
                    alloc_ptr  = alloc_ptr + PTR_W'(len);
                    free_cnt   = free_cnt - PTR_W'(len + SLOT_BYTES);
                    used_slots = used_slots + 1'b1;
                end
            end
            ACT_BYTE: begin
                if (fill_left == 0) begin
                    r.status = ST_NOOPEN;
                end else begin
                    if (fill_ptr < PAGE_BYTES) begin
                        page_bytes[fill_ptr[PAGE_AW-1:0]] = data;
                    end
                    fill_ptr  = fill_ptr + 1'b1;
                    fill_left = fill_left - 1'b1;
                end
            end
            ACT_GET, ACT_DELETE, ACT_READ: begin
                if (act == ACT_READ && fill_left != 0) begin
                    r.status = ST_OPEN;
                end else if (idx >= used_slots) begin
                    r.status = ST_BADSLOT;
                end else if (act == ACT_DELETE) begin
                    slot_size[idx] = '0;
                end else if (slot_size[idx] == 0) begin
                    r.status = ST_DELETED;
                end else begin
                    base = slot_base[idx];
                    size = slot_size[idx];
                    if (act == ACT_READ && (boff >= size || base + boff >= PAGE_BYTES)) begin
                        r.status = ST_BADSLOT;
                    end else begin
                        if (act == ACT_READ) begin
                            r.data = page_bytes[PAGE_AW'(base + boff)];
                        end
                        r.offset = base;
                        r.length = size;
                    end
                end
            end
            default: begin
            end
        endcase
        r.free_left = free_cnt[LEN_W-1:0];
        awaited_responses.push_back(r);
    endfunction

    // Drives one transaction, waits until it is taken, then books its expected result.
    task automatic send_command(input logic [ACT_W-1:0] act,
                                input logic [LEN_W-1:0] len = '0,
                                input logic [BYTE_W-1:0] data = '0,
                                input logic [IDX_W-1:0] idx = '0,
                                input logic [OFF_W-1:0] boff = '0);
        if (gaps_on && $urandom_range(99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_action        <= act;
        i_record_length <= len;
        i_data_byte     <= data;
        i_slot_index    <= idx;
        i_byte_offset   <= boff;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_page_step(act, len, data, idx, boff);
        commands_sent++;
    endtask

    // Mostly a slot that exists, now and then any slot number at all.
    function automatic logic [IDX_W-1:0] pick_slot();
        if (used_slots == 0 || $urandom_range(7) == 0) begin
            return IDX_W'($urandom());
        end
        return IDX_W'($urandom_range(used_slots - 1));
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_page_resp want;
        if (i_rst_n && o_done) begin
            if (awaited_responses.size() == 0) begin
                report_mismatch("result strobe with no transaction outstanding");
            end else begin
                want = awaited_responses.pop_front();
                check_field("status", o_status, want.status);
                check_field("slot_index_out", o_slot_index_out, want.slot);
                check_field("record_offset", o_record_offset, want.offset);
                check_field("record_length_out", o_record_length_out, want.length);
                check_field("data_byte_out", o_data_byte_out, want.data);
                check_field("free_bytes_left", o_free_bytes_left, want.free_left);
            end
        end
    end

    task automatic test_empty_page();
        send_command(ACT_BYTE, '0, 8'hFF);
        send_command(ACT_GET);
        send_command(ACT_DELETE, '0, '0, 10'h3FF);
        send_command(ACT_READ, '0, '0, '0, 12'hFFF);
        send_command(ACT_RSVD_A);
        send_command(ACT_RSVD_B, 12'hFFF, 8'hFF, 10'h3FF, 12'hFFF);
    endtask

    task automatic test_record_lifecycle();
        send_command(ACT_INSERT, 12'd3);
        send_command(ACT_BYTE, '0, 8'h00);
        // A get stays legal while the record is still being filled; a read is refused as open.
        send_command(ACT_GET);
        send_command(ACT_READ);
        send_command(ACT_INSERT, 12'd5);
        send_command(ACT_BYTE, '0, 8'hFF);
        send_command(ACT_BYTE, '0, 8'hA5);
        send_command(ACT_BYTE, '0, 8'h5A);
        send_command(ACT_READ, '0, '0, '0, 12'd2);
        send_command(ACT_READ, '0, '0, '0, 12'd3);
        send_command(ACT_READ, '0, '0, '0, 12'hFFF);
        send_command(ACT_INSERT, 12'd0);
        send_command(ACT_GET, '0, '0, 10'd1);
        send_command(ACT_READ, '0, '0, 10'd1);
        send_command(ACT_DELETE);
        send_command(ACT_DELETE);
        send_command(ACT_GET);
        send_command(ACT_GET, '0, '0, 10'd2);
    endtask

    task automatic test_page_limits();
        send_command(ACT_INIT);
        send_command(ACT_INSERT, 12'hFFF);
        // This record takes every free byte that one slot entry leaves.
        send_command(ACT_INSERT, LEN_W'(PAGE_BYTES - HEADER_BYTES - SLOT_BYTES));
        send_command(ACT_INSERT, 12'd0);
        send_command(ACT_DELETE);
        send_command(ACT_INIT);
        send_command(ACT_BYTE, '0, 8'h3C);
        send_command(ACT_INSERT, 12'd0);
    endtask

    // Packs the directory with short records back to back, then probes its edges.
    task automatic test_directory_fill();
        int k;
        send_command(ACT_INIT);
        gaps_on = 1'b0;
        for (k = 0; k < 80; k++) begin
            if ($urandom_range(7) == 0) begin
                send_command(ACT_INSERT, 12'd1, '0, IDX_W'($urandom()));
                send_command(ACT_BYTE, '0, BYTE_W'($urandom()));
            end else begin
                send_command(ACT_INSERT, 12'd0, BYTE_W'($urandom()), IDX_W'($urandom()),
                             OFF_W'($urandom()));
            end
            if ($urandom_range(31) == 0) begin
                send_command(ACT_GET, '0, '0, pick_slot());
            end
        end
        gaps_on = 1'b1;
        // One byte more than the remaining free bytes can hold.
        send_command(ACT_INSERT, LEN_W'(free_cnt - SLOT_BYTES + 1));
        send_command(ACT_GET, '0, '0, IDX_W'(used_slots - 1));
        send_command(ACT_GET, '0, '0, IDX_W'(used_slots));
        for (k = 0; k < 8; k++) begin
            send_command(ACT_READ, '0, '0, pick_slot(), '0);
        end
        send_command(ACT_INIT);
    endtask

    task automatic test_random_traffic(input int n_items);
        int  first;
        int  pick;
        int  len;
        int  k;
        bit  aborted;
        logic [IDX_W-1:0] slot;
        logic [OFF_W-1:0] boff;
        first = commands_sent;
        send_command(ACT_INIT);
        while (commands_sent - first < n_items) begin
            // A stretch in the middle runs back to back.
            gaps_on = !((commands_sent - first) > n_items / 3 &&
                        (commands_sent - first) < n_items / 2);
            pick = $urandom_range(99);
            if (pick < 50) begin
                len = ($urandom_range(15) == 0) ? $urandom_range(32, 160) : $urandom_range(12);
                if (free_cnt < len + SLOT_BYTES) begin
                    send_command(ACT_INIT);
                end
                send_command(ACT_INSERT, LEN_W'(len), '0, IDX_W'($urandom()));
                aborted = 1'b0;
                for (k = 0; k < len && !aborted; k++) begin
                    case ($urandom_range(39))
                        0: send_command(ACT_READ, '0, '0, pick_slot(), '0);
                        1: send_command(ACT_INSERT, LEN_W'($urandom_range(12)));
                        2: send_command(ACT_GET, '0, '0, pick_slot());
                        3: send_command(ACT_DELETE, '0, '0, pick_slot());
                        4: begin
                            send_command(ACT_INIT);
                            aborted = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    if (!aborted) begin
                        send_command(ACT_BYTE, '0, BYTE_W'($urandom()));
                    end
                end
            end else if (pick < 80) begin
                slot = pick_slot();
                if (pick < 62) begin
                    send_command(ACT_GET, '0, '0, slot);
                end else begin
                    if (slot_size[slot] != 0 && $urandom_range(7) != 0) begin
                        boff = OFF_W'($urandom_range(slot_size[slot] - 1));
                    end else begin
                        boff = OFF_W'($urandom());
                    end
                    send_command(ACT_READ, '0, '0, slot, boff);
                end
            end else if (pick < 88) begin
                send_command(ACT_DELETE, '0, '0, pick_slot());
            end else begin
                send_command(ACT_W'($urandom_range(7)), LEN_W'($urandom()),
                             BYTE_W'($urandom()), IDX_W'($urandom()), OFF_W'($urandom()));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        int drain_cycles;
        clear_page_pointers();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_page();
        test_record_lifecycle();
        test_page_limits();
        test_directory_fill();
        test_random_traffic(310);
        start <= 1'b0;
        drain_cycles = 0;
        while (awaited_responses.size() != 0 && drain_cycles < 2000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (awaited_responses.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_responses.size()));
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
